[rtl/core/pli_pkg.sv]
// shared types and constants for the piecewise linear interpolator
package pli_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_NEW,
        S_SH_RD,
        S_SH_WR,
        S_QRY_RD,
        S_QRY_CMP,
        S_SEG0,
        S_SEG1,
        S_SEG2,
        S_CALC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_FIN
    } t_md_state;

    localparam int unsigned MIN_SEG_POINTS = 2;

endpackage

[rtl/core/pli_ram.sv]
// generic simple dual port ram with registered read
module pli_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/pli_muldiv.sv]
// segment arithmetic: full product, bit-serial restoring divide, saturation
module pli_muldiv
    import pli_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_dx,
    input  logic signed [32:0] i_dy,
    input  logic [31:0]        i_den,
    input  logic signed [31:0] i_y0,
    output logic               o_done,
    output logic signed [31:0] o_y
);

    t_md_state          r_st, n_st;
    logic               r_neg, n_neg;
    logic [31:0]        r_ma, n_ma, r_mb, n_mb, r_den, n_den, r_rem, n_rem;
    logic [63:0]        r_quo, n_quo;
    logic signed [31:0] r_y0, n_y0, r_y, n_y;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_done, n_done;

    logic [32:0]        abs_dx, abs_dy, t, sub;
    logic               ge, big;
    logic [40:0]        mag, sq;
    logic [41:0]        sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= MD_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_y0  <= n_y0;
        r_y   <= n_y;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_st   = r_st;
        n_neg  = r_neg;
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_y0   = r_y0;
        n_y    = r_y;
        n_cnt  = r_cnt;
        n_done = 1'b0;

        abs_dx = i_dx[32] ? 33'(-i_dx) : 33'(i_dx);
        abs_dy = i_dy[32] ? 33'(-i_dy) : 33'(i_dy);
        t      = {r_rem, r_quo[63]};
        sub    = t - {1'b0, r_den};
        ge     = (t >= {1'b0, r_den});
        big    = |r_quo[63:40];
        mag    = {1'b0, r_quo[39:0]};
        sq     = r_neg ? 41'(-mag) : mag;
        sum    = {{10{r_y0[31]}}, r_y0} + {sq[40], sq};

        unique case (r_st)
            MD_IDLE: begin
                if (i_start) begin
                    n_neg = i_dx[32] ^ i_dy[32];
                    n_ma  = abs_dx[31:0];
                    n_mb  = abs_dy[31:0];
                    n_den = i_den;
                    n_y0  = i_y0;
                    n_st  = MD_MUL;
                end
            end
            MD_MUL: begin
                n_quo = r_ma * r_mb;
                n_rem = '0;
                n_cnt = '0;
                n_st  = MD_DIV;
            end
            MD_DIV: begin
                n_rem = ge ? sub[31:0] : t[31:0];
                n_quo = {r_quo[62:0], ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_st = MD_FIN;
                end
            end
            MD_FIN: begin
                if (big) begin
                    n_y = r_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end else if (sum[41:31] == '0 || sum[41:31] == '1) begin
                    n_y = sum[31:0];
                end else begin
                    n_y = sum[41] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end
                n_done = 1'b1;
                n_st   = MD_IDLE;
            end
            default: n_st = MD_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

[rtl/core/piecewise_linear_interpolator.sv]
// piecewise linear interpolator top level: breakpoint table sequencer
//
//  channel | direction | fields                         | handshake
//  input   | in        | i_op, i_key_x, i_value_y       | i_valid / o_stall
//  output  | out       | o_status, o_result_x, o_result_y | o_valid / i_stall
//
// one item at a time; clear and no-op go straight to the hand-over state
// insert: a read and a compare per key scanned, then a read and a write per entry shifted in the ram
// query: a read and a compare per key scanned, S_SEG0..S_SEG2 to fetch the segment, then the divider
// reset empties the table; table ram contents are not cleared
// a held result does not block the table walk, only the final hand-over
module piecewise_linear_interpolator
    import pli_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_key_x,
    input  logic signed [31:0] i_value_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_x,
    output logic signed [31:0] o_result_y
);

    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned AW = $clog2(MAX_POINTS);

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic signed [31:0] r_x, n_x, r_y, n_y, r_x0, n_x0, r_y0, n_y0;
    logic [CW-1:0]      r_cnt, n_cnt, r_idx, n_idx, r_pos, n_pos;
    t_status            r_st, n_st;
    logic signed [31:0] r_ry, n_ry;
    logic               r_ov, n_ov;
    logic [1:0]         r_ostat, n_ostat;
    logic signed [31:0] r_orx, n_orx, r_ory, n_ory;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [63:0]        ram_wdata, ram_rdata;
    logic signed [31:0] rd_key, rd_val;

    logic               md_start, md_done;
    logic signed [32:0] md_dx, md_dy;
    logic [32:0]        md_den;
    logic signed [31:0] md_y;
    logic               accept;

    pli_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    pli_muldiv u_muldiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(md_start),
        .i_dx   (md_dx),
        .i_dy   (md_dy),
        .i_den  (md_den[31:0]),
        .i_y0   (r_y0),
        .o_done (md_done),
        .o_y    (md_y)
    );

    assign rd_key = ram_rdata[63:32];
    assign rd_val = ram_rdata[31:0];
    assign md_dx  = {r_x[31], r_x} - {r_x0[31], r_x0};
    assign md_dy  = {rd_val[31], rd_val} - {r_y0[31], r_y0};
    assign md_den = {rd_key[31], rd_key} - {r_x0[31], r_x0};

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_op    <= n_op;
        r_x     <= n_x;
        r_y     <= n_y;
        r_x0    <= n_x0;
        r_y0    <= n_y0;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_st    <= n_st;
        r_ry    <= n_ry;
        r_ostat <= n_ostat;
        r_orx   <= n_orx;
        r_ory   <= n_ory;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_x       = r_x;
        n_y       = r_y;
        n_x0      = r_x0;
        n_y0      = r_y0;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_st      = r_st;
        n_ry      = r_ry;
        n_ov      = r_ov && i_stall;
        n_ostat   = r_ostat;
        n_orx     = r_orx;
        n_ory     = r_ory;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = {r_x, r_y};
        ram_raddr = r_idx[AW-1:0];
        md_start  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = t_op'(i_op);
                    n_x   = i_key_x;
                    n_y   = i_value_y;
                    n_st  = ST_OK;
                    n_ry  = '0;
                    n_idx = '0;
                    unique case (t_op'(i_op))
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_DONE;
                        end
                        OP_INSERT: n_state = S_INS_RD;
                        OP_QUERY: begin
                            if (r_cnt < CW'(MIN_SEG_POINTS)) begin
                                n_st    = ST_FEW;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_QRY_RD;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_idx == r_cnt) begin
                    n_pos   = r_idx;
                    n_state = S_INS_NEW;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (rd_key < r_x) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_INS_RD;
                end else if (rd_key == r_x) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_pos   = r_idx;
                    n_state = S_INS_NEW;
                end
            end
            S_INS_NEW: begin
                if (r_cnt == CW'(MAX_POINTS)) begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_cnt;
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                // walk down from the end, one entry moved per S_SH_RD / S_SH_WR pass
                if (r_idx == r_pos) begin
                    ram_we  = 1'b1;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_DONE;
                end else begin
                    ram_raddr = AW'(r_idx - CW'(1));
                    n_state   = S_SH_WR;
                end
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = r_idx - CW'(1);
                n_state   = S_SH_RD;
            end
            S_QRY_RD: begin
                if (r_idx == r_cnt) begin
                    n_idx   = r_cnt - CW'(MIN_SEG_POINTS);
                    n_state = S_SEG0;
                end else begin
                    n_state = S_QRY_CMP;
                end
            end
            S_QRY_CMP: begin
                if (rd_key <= r_x) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_QRY_RD;
                end else begin
                    // at or below the first key the first segment is used
                    n_idx   = (r_idx == '0) ? '0 : r_idx - CW'(1);
                    n_state = S_SEG0;
                end
            end
            S_SEG0: n_state = S_SEG1;
            S_SEG1: begin
                n_x0      = rd_key;
                n_y0      = rd_val;
                ram_raddr = AW'(r_idx + CW'(1));
                n_state   = S_SEG2;
            end
            S_SEG2: begin
                md_start = 1'b1;
                n_state  = S_CALC;
            end
            S_CALC: begin
                if (md_done) begin
                    n_ry    = md_y;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_ostat = r_st;
                    n_orx   = (r_op == OP_QUERY) ? r_x : '0;
                    n_ory   = r_ry;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid    = r_ov;
    assign o_status   = r_ostat;
    assign o_result_x = r_orx;
    assign o_result_y = r_ory;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS))
        else $error("point count beyond table size");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_op == OP_CLEAR) |=> r_cnt == '0)
        else $error("clear did not empty table");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |-> (r_cnt == '0 || r_cnt == $past(r_cnt) + CW'(1)))
        else $error("point count moved by more than one");

    a_md_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_done |-> r_state == S_CALC)
        else $error("divider finished outside a query");

endmodule

[verif/tb_piecewise_linear_interpolator.sv]
// self-checking testbench for the piecewise linear interpolator
module tb_piecewise_linear_interpolator
    import pli_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        t_op         op;
        logic [31:0] key_x;
        logic [31:0] value_y;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] res_x;
        logic [31:0] res_y;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_op;
    logic signed [31:0] i_key_x;
    logic signed [31:0] i_value_y;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_status;
    logic signed [31:0] o_result_x;
    logic signed [31:0] o_result_y;

    piecewise_linear_interpolator #(.MAX_POINTS(TABLE_DEPTH)) dut (.*);

    t_item   pending_items[$];
    t_answer expected_answers[$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      sender_hold = 0;
    int      send_gap = 0;
    int      recv_gap = 0;

    // predictor state
    logic signed [31:0] bp_keys[TABLE_DEPTH];
    logic signed [31:0] bp_values[TABLE_DEPTH];
    int                 bp_count = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [31:0] segment_value(logic signed [31:0] x, int left);
        logic signed [63:0]  dx, dy, div;
        logic        [127:0] mag;
        logic        [127:0] quot;
        logic signed [63:0]  sum;
        bit                  neg;
        dx  = 64'(x) - 64'(bp_keys[left]);
        dy  = 64'(bp_values[left + 1]) - 64'(bp_values[left]);
        div = 64'(bp_keys[left + 1]) - 64'(bp_keys[left]);
        neg = (dx < 0) != (dy < 0);
        mag = 128'(dx < 0 ? -dx : dx) * 128'(dy < 0 ? -dy : dy);
        quot = mag / 128'(div);
        // quotients at or beyond 2^40 saturate straight away
        if (quot[127:40] != 0) return neg ? 32'sh80000000 : 32'sh7fffffff;
        sum = 64'(bp_values[left]) + (neg ? -64'(quot) : 64'(quot));
        if (sum > 64'sd2147483647) return 32'sh7fffffff;
        if (sum < -64'sd2147483648) return 32'sh80000000;
        return sum[31:0];
    endfunction

    function automatic t_answer interpolate_step(t_item it);
        t_answer a;
        int      pos, k, left;
        logic signed [31:0] x;
        a = '{ST_OK, 32'd0, 32'd0};
        x = it.key_x;
        case (it.op)
            OP_CLEAR: bp_count = 0;
            OP_INSERT: begin
                pos = 0;
                while (pos < bp_count && bp_keys[pos] < x) pos++;
                if (pos < bp_count && bp_keys[pos] == x) begin
                    bp_values[pos] = it.value_y;
                end else if (bp_count >= TABLE_DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    for (k = bp_count; k > pos; k--) begin
                        bp_keys[k]   = bp_keys[k - 1];
                        bp_values[k] = bp_values[k - 1];
                    end
                    bp_keys[pos]   = x;
                    bp_values[pos] = it.value_y;
                    bp_count++;
                end
            end
            OP_QUERY: begin
                a.res_x = x;
                if (bp_count < 2) begin
                    a.status = ST_FEW;
                end else begin
                    if (x <= bp_keys[0]) begin
                        left = 0;
                    end else begin
                        k = 0;
                        while (k < bp_count && bp_keys[k] <= x) k++;
                        left = (k >= bp_count) ? bp_count - 2 : k - 1;
                    end
                    a.res_y = segment_value(x, left);
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    task automatic push(t_op op, logic [31:0] x, logic [31:0] y);
        pending_items.push_back('{op, x, y});
    endtask

    function automatic logic [31:0] rand_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom();
        if (r == 1) return ($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h80000000;
        return 32'($signed($urandom_range(0, 2000)) - 1000) <<< $urandom_range(0, 16);
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0; i_op <= OP_NOP; i_key_x <= 0; i_value_y <= 0;
            send_gap <= 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) expected_answers.push_back(interpolate_step(t_item'{t_op'(i_op),
                i_key_x, i_value_y}));
            if (send_gap > 0 || sender_hold || pending_items.size() == 0) begin
                i_valid <= 0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                t_item it;
                it = pending_items.pop_front();
                i_valid <= 1; i_op <= it.op; i_key_x <= it.key_x; i_value_y <= it.value_y;
                send_gap <= pick_gap();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected item", o_result_x, 32'd0);
                end else begin
                    t_answer w;
                    w = expected_answers.pop_front();
                    if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                    if (o_result_x !== w.res_x) report_mismatch("result_x", o_result_x, w.res_x);
                    if (o_result_y !== w.res_y) report_mismatch("result_y", o_result_y, w.res_y);
                end
            end
            if (recv_gap > 0) begin
                i_stall <= 1; recv_gap <= recv_gap - 1;
            end else begin
                i_stall <= 0; recv_gap <= pick_gap();
            end
        end
    end

    initial begin
        int i, n, mode;
        i_rst_n = 0;
        // directed: too few points, extremes, nop, overwrite, both extrapolations
        push(OP_QUERY, 32'h0, 32'h0);
        push(OP_INSERT, 32'h80000000, 32'h80000000);
        push(OP_QUERY, 32'h7fffffff, 32'h1);
        push(OP_INSERT, 32'h7fffffff, 32'h7fffffff);
        push(OP_QUERY, 32'h0, 32'hffffffff);
        push(OP_QUERY, 32'h80000000, 32'h0);
        push(OP_QUERY, 32'h7fffffff, 32'h0);
        push(OP_NOP, 32'hffffffff, 32'hffffffff);
        push(OP_INSERT, 32'h00010000, 32'h80000000);
        push(OP_INSERT, 32'h00010000, 32'h7fffffff);
        push(OP_QUERY, 32'h00008000, 32'h0);
        push(OP_CLEAR, 32'h0, 32'h0);
        push(OP_INSERT, 32'h0, 32'h7fffffff);
        push(OP_INSERT, 32'h1, 32'h80000000);
        push(OP_QUERY, 32'h80000000, 32'h0);
        push(OP_QUERY, 32'h7fffffff, 32'h0);
        push(OP_QUERY, 32'h1, 32'h0);
        push(OP_CLEAR, 32'h0, 32'h0);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        while (pending_items.size() > 0 || i_valid) @(posedge i_clk);
        // hold the sender until the pipeline has drained
        sender_hold <= 1;
        while (expected_answers.size() > 0) @(posedge i_clk);
        sender_hold <= 0;
        // random sequences: build a table, query it, occasionally fill it
        n = 0;
        while (n < 900) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                for (i = 0; i < 70; i++) push(OP_INSERT, $urandom(), $urandom());
                for (i = 0; i < 5; i++) push(OP_QUERY, $urandom(), 0);
                n += 75;
            end else begin
                if (mode < 4) push(OP_CLEAR, $urandom(), $urandom());
                for (i = $urandom_range(0, 6); i > 0; i--)
                    push(OP_INSERT, rand_key(), $urandom_range(0, 3) == 0 ? $urandom()
                         : 32'($signed($urandom_range(0, 4000)) - 2000) <<< 8);
                for (i = $urandom_range(1, 8); i > 0; i--)
                    push(t_op'($urandom_range(0, 15) == 0 ? OP_NOP : OP_QUERY), rand_key(),
                         $urandom());
                n += 10;
            end
        end
        while (pending_items.size() > 0 || i_valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("tb: failure");
            $finish;
        end
    end

endmodule
